// ===== hw/rtl/slrp_pkg.sv =====
// ----------------------------------------------------------------------------
// slrp_pkg
// Shared types, constants and helper functions of the log record parser.
// ----------------------------------------------------------------------------
package slrp_pkg;

   // Table geometry.
   localparam int MaxFormats       = 64;
   localparam int LettersPerFormat = 16;
   localparam int EntryW           = $clog2(MaxFormats);
   localparam int CountW           = $clog2(MaxFormats + 1);
   localparam int LetterW          = $clog2(LettersPerFormat);

   // Format-definition payload layout.
   localparam int FmtPayloadLen = 86;
   localparam int FmtLetterOfs  = 6;
   localparam int PosW          = 7;

   // Field kind codes.
   localparam logic [3:0] KIND_S8      = 4'd0;
   localparam logic [3:0] KIND_U8      = 4'd1;
   localparam logic [3:0] KIND_S16     = 4'd2;
   localparam logic [3:0] KIND_U16     = 4'd3;
   localparam logic [3:0] KIND_S32     = 4'd4;
   localparam logic [3:0] KIND_U32     = 4'd5;
   localparam logic [3:0] KIND_FLOAT   = 4'd6;
   localparam logic [3:0] KIND_S16C    = 4'd7;
   localparam logic [3:0] KIND_U16C    = 4'd8;
   localparam logic [3:0] KIND_S32C    = 4'd9;
   localparam logic [3:0] KIND_U32C    = 4'd10;
   localparam logic [3:0] KIND_NAME4   = 4'd11;
   localparam logic [3:0] KIND_NAME16  = 4'd12;
   localparam logic [3:0] KIND_TEXT64  = 4'd13;
   localparam logic [3:0] KIND_NONE    = 4'd15;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_FMT_TYPE    = 2'd2;

   // Register reset values.
   localparam logic [7:0] SyncFirstReset  = 8'hA3;
   localparam logic [7:0] SyncSecondReset = 8'h95;
   localparam logic [7:0] FmtTypeReset    = 8'd128;

   // One byte of a field, as handed from the front to the back.
   typedef struct packed {
      logic [7:0]         rec_type;
      logic [LetterW-1:0] field_index;
      logic [3:0]         kind;
      logic [7:0]         data;
      logic [5:0]         byte_idx;
      logic               done;
      logic               last;
   } field_byte_type;

   // Result of a lowest-set-bit search.
   typedef struct packed {
      logic               found;
      logic [LetterW-1:0] idx;
   } first_set_type;

   // Map a format letter to its field kind.
   function automatic logic [3:0] kind_of(input logic [7:0] letter);
      logic [3:0] k;
      case (letter)
         "b":      k = KIND_S8;
         "B", "M": k = KIND_U8;
         "h":      k = KIND_S16;
         "H":      k = KIND_U16;
         "i", "L": k = KIND_S32;
         "I":      k = KIND_U32;
         "f":      k = KIND_FLOAT;
         "c":      k = KIND_S16C;
         "C":      k = KIND_U16C;
         "e":      k = KIND_S32C;
         "E":      k = KIND_U32C;
         "n":      k = KIND_NAME4;
         "N":      k = KIND_NAME16;
         "Z":      k = KIND_TEXT64;
         default:  k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Number of payload bytes that a field kind takes.
   function automatic logic [6:0] size_of(input logic [3:0] k);
      logic [6:0] s;
      case (k)
         KIND_S8, KIND_U8:                         s = 7'd1;
         KIND_S16, KIND_U16, KIND_S16C, KIND_U16C: s = 7'd2;
         KIND_S32, KIND_U32, KIND_FLOAT, KIND_S32C,
         KIND_U32C, KIND_NAME4:                    s = 7'd4;
         KIND_NAME16:                              s = 7'd16;
         KIND_TEXT64:                              s = 7'd64;
         default:                                  s = 7'd0;
      endcase
      return s;
   endfunction

   // Lowest set bit of the known-letter mask at a position above lim,
   // or at any position when any_pos is set.
   function automatic first_set_type first_known(input logic [LettersPerFormat-1:0] mask,
                                                 input logic [LetterW-1:0] lim,
                                                 input logic any_pos);
      first_set_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = LettersPerFormat - 1; i >= 0; i--) begin
         if (mask[i] && (any_pos || (LetterW'(i) > lim))) begin
            r.found = 1'b1;
            r.idx   = LetterW'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/self_describing_log_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// self_describing_log_record_parser_unit
// Binary log parser: finds record headers, learns format definitions and
// decodes data records field by field.
//
// Channel  Direction  Payload
// req_     in         tdata[7:0] raw_byte
// rsp_     out        tdata: record_type, field_index, field_kind, field_value,
//                     char_index; tlast: last_in_record
// csr_     in         csr_index (0 sync_first, 1 sync_second, 2 format type),
//                     csr_data
//
// One byte is taken per cycle in hunting, header and format phases, and in
// decode while the queue is not full. After a type byte, the format table is
// searched entry by entry in search and compare states with the input stalled.
// A four-entry queue and the output register let the intake keep running
// while the result side is stalled. Reset is synchronous; the table needs no
// clearing since only filled entries are searched.
// ----------------------------------------------------------------------------
module self_describing_log_record_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] record_type, [11:8] field_index,
                                    // [15:12] field_kind, [48:16] field_value,
                                    // [54:49] char_index, [55] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   slrp_pkg::field_byte_type push_data, pop_data;
   logic              push_valid, q_full, q_valid, q_pop;
   logic [7:0]        record_type;
   logic [3:0]        field_index, field_kind;
   logic signed [32:0] field_value;
   logic [5:0]        char_index;

   assign csr_ready = 1'b1;

   // Intake and classification.
   slrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_full  (q_full),
      .push_data  (push_data)
   );

   // Decoupling queue.
   slrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_data)
   );

   // Value assembly and result register.
   slrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_type  (record_type),
      .out_index (field_index),
      .out_kind  (field_kind),
      .out_value (field_value),
      .out_char  (char_index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, char_index, field_value, field_kind, field_index, record_type};

endmodule

// ===== hw/rtl/slrp_front.sv =====
// ----------------------------------------------------------------------------
// slrp_front
// Byte intake: sync hunting, format-table capture, type search and field
// walking. Emits one descriptor per payload byte of a decoded record.
// ----------------------------------------------------------------------------
module slrp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   output logic                    byte_ready,
   input  logic [7:0]              byte_data,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_data,
   output logic                    push_valid,
   input  logic                    push_full,
   output slrp_pkg::field_byte_type push_data
);

   localparam int RowW = slrp_pkg::LettersPerFormat * 5;

   localparam logic [2:0] ST_HUNT1  = 3'd0;
   localparam logic [2:0] ST_HUNT2  = 3'd1;
   localparam logic [2:0] ST_TYPE   = 3'd2;
   localparam logic [2:0] ST_FORMAT = 3'd3;
   localparam logic [2:0] ST_SEARCH = 3'd4;
   localparam logic [2:0] ST_CMP    = 3'd5;
   localparam logic [2:0] ST_DECODE = 3'd6;

   // Configuration registers.
   logic [7:0] sync_first_ff, sync_second_ff, fmt_type_ff;

   // Parser state.
   logic [2:0]                         state_ff, state_in;
   logic [7:0]                         held_ff, held_in;
   logic [7:0]                         cur_type_ff, cur_type_in;
   logic [slrp_pkg::CountW-1:0]        count_ff, count_in;
   logic [slrp_pkg::PosW-1:0]          pos_ff, pos_in;
   logic [7:0]                         def_type_ff, def_type_in;
   logic [slrp_pkg::LettersPerFormat*4-1:0] def_kinds_ff, def_kinds_in;
   logic [slrp_pkg::LettersPerFormat-1:0]   def_mask_ff, def_mask_in;
   logic                               zero_seen_ff, zero_seen_in;
   logic [slrp_pkg::EntryW-1:0]        srch_ff, srch_in;
   logic [RowW-1:0]                    row_ff, row_in;
   logic [slrp_pkg::LetterW-1:0]       lpos_ff, lpos_in;
   logic [5:0]                         bif_ff, bif_in;

   // Format table: entry types and per-entry rows of kinds plus known mask.
   logic [7:0]      types_mem [slrp_pkg::MaxFormats];
   logic [RowW-1:0] rows_mem  [slrp_pkg::MaxFormats];
   logic [7:0]      types_rd_ff;
   logic [RowW-1:0] rows_rd_ff;
   logic            tbl_we;

   logic                         take;
   logic [slrp_pkg::LetterW-1:0] letter_idx;
   logic [3:0]                   letter_kind;
   logic [3:0]                   cur_kind;
   logic [6:0]                   cur_size;
   logic                         field_done;
   slrp_pkg::first_set_type      nxt, first;

   assign byte_ready = (state_ff == ST_HUNT1) || (state_ff == ST_HUNT2) ||
                       (state_ff == ST_TYPE) || (state_ff == ST_FORMAT) ||
                       ((state_ff == ST_DECODE) && !push_full);
   assign take = byte_valid && byte_ready;

   // Field walk helpers for the current record.
   assign cur_kind   = row_ff[lpos_ff*4 +: 4];
   assign cur_size   = slrp_pkg::size_of(cur_kind);
   assign field_done = ({1'b0, bif_ff} + 7'd1) >= cur_size;
   assign nxt        = slrp_pkg::first_known(row_ff[RowW-1 -: slrp_pkg::LettersPerFormat],
                                             lpos_ff, 1'b0);
   assign first      = slrp_pkg::first_known(rows_rd_ff[RowW-1 -: slrp_pkg::LettersPerFormat],
                                             '0, 1'b1);

   // Letter capture within a format payload.
   assign letter_idx  = slrp_pkg::LetterW'(pos_ff - slrp_pkg::PosW'(slrp_pkg::FmtLetterOfs));
   assign letter_kind = slrp_pkg::kind_of(byte_data);
   assign tbl_we      = take && (state_ff == ST_FORMAT) &&
                        (pos_ff == slrp_pkg::PosW'(slrp_pkg::FmtPayloadLen - 1)) &&
                        (count_ff < slrp_pkg::CountW'(slrp_pkg::MaxFormats));

   // Descriptor toward the back.
   assign push_valid            = take && (state_ff == ST_DECODE);
   assign push_data.rec_type    = cur_type_ff;
   assign push_data.field_index = lpos_ff;
   assign push_data.kind        = cur_kind;
   assign push_data.data        = byte_data;
   assign push_data.byte_idx    = bif_ff;
   assign push_data.done        = field_done;
   assign push_data.last        = field_done && !nxt.found;

   // Next-state logic of the parser.
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      cur_type_in  = cur_type_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      def_type_in  = def_type_ff;
      def_kinds_in = def_kinds_ff;
      def_mask_in  = def_mask_ff;
      zero_seen_in = zero_seen_ff;
      srch_in      = srch_ff;
      row_in       = row_ff;
      lpos_in      = lpos_ff;
      bif_in       = bif_ff;
      case (state_ff)
         ST_HUNT1: begin
            if (take) begin
               held_in  = byte_data;
               state_in = ST_HUNT2;
            end
         end
         ST_HUNT2: begin
            if (take) begin
               state_in = (held_ff == sync_first_ff && byte_data == sync_second_ff) ?
                          ST_TYPE : ST_HUNT1;
            end
         end
         ST_TYPE: begin
            if (take) begin
               cur_type_in = byte_data;
               if (byte_data == fmt_type_ff) begin
                  pos_in       = '0;
                  zero_seen_in = 1'b0;
                  def_mask_in  = '0;
                  def_kinds_in = '0;
                  state_in     = ST_FORMAT;
               end else if (count_ff == '0) begin
                  state_in = ST_HUNT1;
               end else begin
                  srch_in  = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_FORMAT: begin
            if (take) begin
               if (pos_ff == '0) begin
                  def_type_in = byte_data;
               end
               if (pos_ff >= slrp_pkg::PosW'(slrp_pkg::FmtLetterOfs) &&
                   pos_ff < slrp_pkg::PosW'(slrp_pkg::FmtLetterOfs +
                                            slrp_pkg::LettersPerFormat)) begin
                  def_kinds_in[letter_idx*4 +: 4] = letter_kind;
                  if (byte_data == 8'd0) begin
                     zero_seen_in = 1'b1;
                  end
                  def_mask_in[letter_idx] = !zero_seen_ff && (byte_data != 8'd0) &&
                                            (letter_kind != slrp_pkg::KIND_NONE);
               end
               if (pos_ff == slrp_pkg::PosW'(slrp_pkg::FmtPayloadLen - 1)) begin
                  if (count_ff < slrp_pkg::CountW'(slrp_pkg::MaxFormats)) begin
                     count_in = count_ff + 1'b1;
                  end
                  pos_in   = '0;
                  state_in = ST_HUNT1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (types_rd_ff == cur_type_ff) begin
               row_in  = rows_rd_ff;
               lpos_in = first.idx;
               bif_in  = '0;
               state_in = first.found ? ST_DECODE : ST_HUNT1;
            end else if (({1'b0, srch_ff} + 1'b1) >= count_ff) begin
               state_in = ST_HUNT1;
            end else begin
               srch_in  = srch_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_DECODE: begin
            if (take) begin
               if (field_done) begin
                  bif_in = '0;
                  if (nxt.found) begin
                     lpos_in = nxt.idx;
                  end else begin
                     state_in = ST_HUNT1;
                  end
               end else begin
                  bif_in = bif_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_HUNT1;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_HUNT1;
         count_ff       <= '0;
         sync_first_ff  <= slrp_pkg::SyncFirstReset;
         sync_second_ff <= slrp_pkg::SyncSecondReset;
         fmt_type_ff    <= slrp_pkg::FmtTypeReset;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid) begin
            case (csr_index)
               slrp_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_data;
               slrp_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_data;
               slrp_pkg::CSR_FMT_TYPE:    fmt_type_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      cur_type_ff  <= cur_type_in;
      pos_ff       <= pos_in;
      def_type_ff  <= def_type_in;
      def_kinds_ff <= def_kinds_in;
      def_mask_ff  <= def_mask_in;
      zero_seen_ff <= zero_seen_in;
      srch_ff      <= srch_in;
      row_ff       <= row_in;
      lpos_ff      <= lpos_in;
      bif_ff       <= bif_in;
   end

   // Format table memories: one write at the end of a definition while the table
   // has room, one read per search step.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         types_mem[count_ff[slrp_pkg::EntryW-1:0]] <= def_type_ff;
         rows_mem[count_ff[slrp_pkg::EntryW-1:0]]  <= {def_mask_ff, def_kinds_ff};
      end
      types_rd_ff <= types_mem[srch_ff];
      rows_rd_ff  <= rows_mem[srch_ff];
   end

endmodule

// ===== hw/rtl/slrp_queue.sv =====
// ----------------------------------------------------------------------------
// slrp_queue
// Four-entry queue of field-byte descriptors between front and back.
// ----------------------------------------------------------------------------
module slrp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  slrp_pkg::field_byte_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output slrp_pkg::field_byte_type pop_data
);

   slrp_pkg::field_byte_type slots_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] fill_ff;

   assign full      = (fill_ff == 3'd4);
   assign not_empty = (fill_ff != 3'd0);
   assign pop_data  = slots_ff[rd_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         fill_ff <= fill_ff + {2'b00, push} - {2'b00, pop};
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/slrp_back.sv =====
// ----------------------------------------------------------------------------
// slrp_back
// Field assembly: gathers little-endian bytes, extends the value by kind and
// holds one result in an output register.
// ----------------------------------------------------------------------------
module slrp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  slrp_pkg::field_byte_type q_data,
   output logic                     q_pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [7:0]               out_type,
   output logic [3:0]               out_index,
   output logic [3:0]               out_kind,
   output logic signed [32:0]       out_value,
   output logic [5:0]               out_char,
   output logic                     out_last
);

   logic        valid_ff, valid_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] acc_sum;
   logic        is_str;
   logic        produce;
   logic [32:0] value;
   logic [7:0]  type_ff;
   logic [3:0]  index_ff, kind_ff;
   logic [32:0] value_ff;
   logic [5:0]  char_ff;
   logic        last_ff;

   assign q_pop   = q_valid && (!valid_ff || out_ready);
   assign is_str  = (q_data.kind == slrp_pkg::KIND_NAME4) ||
                    (q_data.kind == slrp_pkg::KIND_NAME16) ||
                    (q_data.kind == slrp_pkg::KIND_TEXT64);
   assign produce = q_pop && (is_str || q_data.done);

   // Merge the byte into the accumulator at its lane.
   always_comb begin
      acc_sum = acc_ff;
      if (q_data.byte_idx < 6'd4) begin
         acc_sum = acc_ff | ({24'd0, q_data.data} << {q_data.byte_idx[1:0], 3'b000});
      end
   end

   // Sign or zero extension by kind.
   always_comb begin
      case (q_data.kind)
         slrp_pkg::KIND_S8:                     value = {{25{acc_sum[7]}}, acc_sum[7:0]};
         slrp_pkg::KIND_S16, slrp_pkg::KIND_S16C: value = {{17{acc_sum[15]}}, acc_sum[15:0]};
         slrp_pkg::KIND_S32, slrp_pkg::KIND_S32C: value = {acc_sum[31], acc_sum};
         default:                               value = {1'b0, acc_sum};
      endcase
   end

   // Accumulator and output valid.
   always_comb begin
      acc_in   = acc_ff;
      valid_in = valid_ff && !out_ready;
      if (q_pop && !is_str) begin
         acc_in = q_data.done ? 32'd0 : acc_sum;
      end
      if (produce) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (produce) begin
         type_ff  <= q_data.rec_type;
         index_ff <= q_data.field_index;
         kind_ff  <= q_data.kind;
         value_ff <= is_str ? {25'd0, q_data.data} : value;
         char_ff  <= is_str ? q_data.byte_idx : 6'd0;
         last_ff  <= q_data.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_type  = type_ff;
   assign out_index = index_ff;
   assign out_kind  = kind_ff;
   assign out_value = value_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// ===== hw/rtl/slrp_checker.sv =====
// ----------------------------------------------------------------------------
// slrp_checker
// Port-level checks of the log record parser, bound to its top level.
// ----------------------------------------------------------------------------
module slrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its contents.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A character position appears only on string kinds.
   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[54:49] != 6'd0) |->
         (rsp_tdata[15:12] == slrp_pkg::KIND_NAME4) ||
         (rsp_tdata[15:12] == slrp_pkg::KIND_NAME16) ||
         (rsp_tdata[15:12] == slrp_pkg::KIND_TEXT64))
      else $error("character index on a numeric field");

   // Signed byte fields carry a proper extension.
   a_s8_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:12] == slrp_pkg::KIND_S8) |->
         (rsp_tdata[48:23] == {26{rsp_tdata[23]}}))
      else $error("bad extension of a signed byte field");

endmodule

bind self_describing_log_record_parser_unit slrp_checker u_slrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
